// ===== rtl/lss_pkg.sv =====
package lss_pkg;

    localparam int SLOTS          = 8;
    localparam int SLOT_W         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TAG_W          = 12;
    localparam int AGE_W          = 16;
    localparam int IDX_W          = 3;
    localparam int RESET_TAG_BASE = 4000;
    localparam int RESET_AGE      = 9999;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch request, clear scan state
        logic scan;    // examine one slot
        logic commit;  // update table on a miss, load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
    } t_sts;

endpackage

// ===== rtl/lss_ctrl.sv =====
module lss_ctrl import lss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_COMMIT: begin
                o_cmd.commit = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/lss_dp.sv =====
module lss_dp import lss_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [TAG_W-1:0] i_fault_segment,
    input  logic [TAG_W-1:0] i_instruction_segment,
    output t_sts             o_sts,
    output logic [IDX_W-1:0] o_slot_index,
    output logic             o_was_hit,
    output logic [TAG_W-1:0] o_evicted_segment
);

    logic [TAG_W-1:0]  r_tags [SLOTS];
    logic [AGE_W-1:0]  r_ages [SLOTS];

    logic [TAG_W-1:0]  r_fseg;
    logic [TAG_W-1:0]  r_iseg;
    logic [SLOT_W-1:0] r_idx;
    logic              r_hit;
    logic [SLOT_W-1:0] r_hit_idx;
    logic              r_elig;
    logic [SLOT_W-1:0] r_pick;
    logic [AGE_W-1:0]  r_best;
    logic [TAG_W-1:0]  r_old_tag;

    logic [IDX_W-1:0]  r_slot_index;
    logic              r_was_hit;
    logic [TAG_W-1:0]  r_evicted;

    logic [TAG_W-1:0]  cur_tag;
    logic [AGE_W-1:0]  cur_age;
    logic              cur_match;
    logic              cur_elig;
    logic              cur_older;

    assign cur_tag   = r_tags[r_idx];
    assign cur_age   = r_ages[r_idx];
    assign cur_match = (cur_tag == r_fseg);
    assign cur_elig  = (cur_tag != r_iseg);
    assign cur_older = (cur_age > r_best);

    assign o_sts.scan_last = (r_idx == SLOT_W'(SLOTS - 1));

    // scan state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fseg    <= i_fault_segment;
            r_iseg    <= i_instruction_segment;
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_hit_idx <= '0;
            r_elig    <= 1'b0;
            r_pick    <= '0;
            r_best    <= '0;
            r_old_tag <= r_tags[0];   // victim when no slot is eligible
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + 1'b1;
            if (!r_hit && cur_match) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_idx;
            end
            if (cur_elig) begin
                r_elig <= 1'b1;
                if (cur_older) begin
                    r_best    <= cur_age;
                    r_pick    <= r_idx;
                    r_old_tag <= cur_tag;
                end else if (!r_elig) begin
                    r_pick    <= r_idx;
                    r_old_tag <= cur_tag;
                end
            end
        end
    end

    // slot table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_tags[k] <= TAG_W'(RESET_TAG_BASE + k);
                r_ages[k] <= AGE_W'(RESET_AGE);
            end
        end else if (i_cmd.commit && !r_hit) begin
            for (int k = 0; k < SLOTS; k++) begin
                if (SLOT_W'(k) == r_pick) begin
                    r_ages[k] <= '0;
                    r_tags[k] <= r_fseg;
                end else if (r_ages[k] != AGE_MAX) begin
                    r_ages[k] <= r_ages[k] + 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_was_hit <= r_hit;
            if (r_hit) begin
                r_slot_index <= IDX_W'(r_hit_idx);
                r_evicted    <= r_fseg;
            end else begin
                r_slot_index <= IDX_W'(r_pick);
                r_evicted    <= r_old_tag;
            end
        end
    end

    assign o_slot_index      = r_slot_index;
    assign o_was_hit         = r_was_hit;
    assign o_evicted_segment = r_evicted;

endmodule

// ===== rtl/lru_segment_slot_select.sv =====
// Segment slot selector with age-counter LRU replacement.
//
// Input channel: i_in_valid / o_in_stall carry one request item, the
// faulting segment and the segment of the faulting instruction. An item is
// taken at a rising edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carry one result item per
// request: slot index, hit flag and the tag the slot held before.
// Sequence: after acceptance the slot table is walked one slot per cycle,
// then a commit step, on a miss, updates ages and the victim's tag, and
// always loads the result register. No new item is taken until the last
// one has been committed; the scan walks the table through the single
// table read port.
// The result register parts the two sides: while a result waits under
// i_out_stall the next item is still taken and scanned, and only its commit
// waits until the register frees up.
// Reset (synchronous, active low) loads tag 4000 + slot number and age 9999
// into every slot, empties the result register and makes the block ready.
module lru_segment_slot_select import lss_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [TAG_W-1:0] i_fault_segment,
    input  logic [TAG_W-1:0] i_instruction_segment,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [IDX_W-1:0] o_slot_index,
    output logic             o_was_hit,
    output logic [TAG_W-1:0] o_evicted_segment
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: idle -> scan (one slot a cycle) -> commit
    lss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // slot table, hit / victim search, result register
    lss_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .i_fault_segment       (i_fault_segment),
        .i_instruction_segment (i_instruction_segment),
        .o_sts                 (sts),
        .o_slot_index          (o_slot_index),
        .o_was_hit             (o_was_hit),
        .o_evicted_segment     (o_evicted_segment)
    );

endmodule

// ===== rtl/lss_chk.sv =====
module lss_chk import lss_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [IDX_W-1:0] o_slot_index,
    input logic             o_was_hit,
    input logic [TAG_W-1:0] o_evicted_segment
);

    // block is busy after an item is accepted and still busy in the last scan step
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("not busy after item accepted");

    a_busy_through_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> ##SLOTS o_in_stall)
        else $error("ready again before scan finished");

    // a fresh result only appears from the commit cycle
    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while idle");

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("reset left block busy or result pending");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_slot_index) && $stable(o_was_hit)
             && $stable(o_evicted_segment)))
        else $error("stalled result changed");

endmodule

bind lru_segment_slot_select lss_chk u_lss_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_slot_index      (o_slot_index),
    .o_was_hit         (o_was_hit),
    .o_evicted_segment (o_evicted_segment)
);
